/* hw/rtl/brc_pkg.sv */
// Shared types and constants of the binary range coder size counter.
`default_nettype none
package brc_pkg;

  localparam int unsigned CountBitsDefault = 40;
  localparam int unsigned TotalBits        = 40;
  localparam int unsigned RangeBits        = 32;
  localparam int unsigned ProbBits         = 16;
  localparam int unsigned ShiftCntBits     = 3;

  localparam logic [ProbBits-1:0]     ProbMin   = 16'd1;
  localparam logic [ProbBits-1:0]     ProbMax   = 16'hffff;
  localparam logic [RangeBits-1:0]    FullRange = 32'hffff_ffff;
  localparam logic [7:0]              FillByte  = 8'hff;
  localparam logic [ShiftCntBits-1:0] ShiftMax  = 3'd4;

  typedef enum logic {
    CmdEncode = 1'b0,
    CmdFinish = 1'b1
  } cmd_e;

  typedef enum logic [6:0] {
    StIdle   = 7'b0000001,
    StMulA   = 7'b0000010,
    StMulB   = 7'b0000100,
    StUpdate = 7'b0001000,
    StShift  = 7'b0010000,
    StFlush  = 7'b0100000,
    StDone   = 7'b1000000
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic mul_hi;
    logic acc_en;
    logic update;
    logic shift;
    logic count;
    logic clear;
  } ctrl_t;

endpackage
`default_nettype wire

/* hw/rtl/brc_if.sv */
// Handshake channels for coder items and size results.
`default_nettype none
interface brc_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd;
  logic                          coded_bit;
  logic [brc_pkg::ProbBits-1:0]  prob_one;

  modport source (output valid, output cmd, output coded_bit, output prob_one, input ready);
  modport sink   (input valid, input cmd, input coded_bit, input prob_one, output ready);
endinterface

interface brc_out_if;
  logic                          valid;
  logic                          ready;
  logic [brc_pkg::TotalBits-1:0] byte_total;
  logic                          is_final;

  modport source (output valid, output byte_total, output is_final, input ready);
  modport sink   (input valid, input byte_total, input is_final, output ready);
endinterface
`default_nettype wire

/* hw/rtl/brc_mul.sv */
// Shared 16 by 16 multiplier with registered product.
`default_nettype none
module brc_mul (
  input  wire                                  clk_i,
  input  wire                                  en_i,
  input  wire  [brc_pkg::ProbBits-1:0]         a_i,
  input  wire  [brc_pkg::ProbBits-1:0]         b_i,
  output logic [2*brc_pkg::ProbBits-1:0]       prod_o
);

  logic [2*brc_pkg::ProbBits-1:0] prod_q, prod_d;

  assign prod_d = {{brc_pkg::ProbBits{1'b0}}, a_i} * {{brc_pkg::ProbBits{1'b0}}, b_i};
  assign prod_o = prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/brc_core.sv */
// Interval bounds, midpoint arithmetic, byte shifter and saturating byte counter.
`default_nettype none
module brc_core #(
  parameter int unsigned COUNT_BITS = brc_pkg::CountBitsDefault
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  brc_pkg::ctrl_t                    ctrl_i,
  input  wire                               coded_bit_i,
  input  wire  [brc_pkg::ProbBits-1:0]      prob_one_i,
  output logic                              top_eq_o,
  output logic [COUNT_BITS-1:0]             count_o
);

  localparam int unsigned RB = brc_pkg::RangeBits;
  localparam int unsigned PB = brc_pkg::ProbBits;

  logic [RB-1:0]         low_q, high_q;
  logic [RB-1:0]         span_q, acc_q;
  logic [PB-1:0]         p_q, p_clamp;
  logic                  sym_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [2*PB-1:0]       prod;
  logic [PB-1:0]         mul_a;
  logic [RB-1:0]         mid;

  // Clamp zero up to the smallest probability.
  always_comb begin
    p_clamp = prob_one_i;
    if (p_clamp < brc_pkg::ProbMin) p_clamp = brc_pkg::ProbMin;
    if (p_clamp > brc_pkg::ProbMax) p_clamp = brc_pkg::ProbMax;
  end

  assign mul_a = ctrl_i.mul_hi ? span_q[RB-1:PB] : span_q[PB-1:0];

  brc_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (ctrl_i.mul_en),
    .a_i    (mul_a),
    .b_i    (p_q),
    .prod_o (prod)
  );

  // Low partial product contributes only its upper half.
  assign mid      = acc_q + {{(RB-PB){1'b0}}, prod[2*PB-1:PB]};
  assign top_eq_o = (low_q[RB-1:RB-8] == high_q[RB-1:RB-8]);
  assign count_o  = cnt_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      span_q <= high_q - low_q;
      p_q    <= p_clamp;
      sym_q  <= coded_bit_i;
    end
    if (ctrl_i.acc_en) begin
      acc_q <= low_q + prod;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= '0;
      high_q <= brc_pkg::FullRange;
      cnt_q  <= '0;
    end else if (ctrl_i.clear) begin
      low_q  <= '0;
      high_q <= brc_pkg::FullRange;
      cnt_q  <= '0;
    end else begin
      if (ctrl_i.update) begin
        if (sym_q) high_q <= mid;
        else       low_q  <= mid + {{(RB-1){1'b0}}, 1'b1};
      end
      if (ctrl_i.shift) begin
        low_q  <= {low_q[RB-9:0], 8'h00};
        high_q <= {high_q[RB-9:0], brc_pkg::FillByte};
      end
      // Hold at the top of the range.
      if ((ctrl_i.shift || ctrl_i.count) && !(&cnt_q)) begin
        cnt_q <= cnt_q + {{(COUNT_BITS-1){1'b0}}, 1'b1};
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/brc_ctrl.sv */
// Sequencer stepping the shared multiplier, interval update and byte shifts.
`default_nettype none
module brc_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  input  wire             in_cmd_i,
  input  wire             top_eq_i,
  input  wire             out_free_i,
  output logic            in_ready_o,
  output logic            out_load_o,
  output logic            is_final_o,
  output brc_pkg::ctrl_t  ctrl_o
);

  brc_pkg::state_e state_q, state_d;
  brc_pkg::cmd_e   cmd_q, cmd_d;
  logic [brc_pkg::ShiftCntBits-1:0] sh_cnt_q, sh_cnt_d;

  assign is_final_o = (cmd_q == brc_pkg::CmdFinish);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    sh_cnt_d   = sh_cnt_q;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    ctrl_o     = '0;
    case (state_q)
      brc_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          cmd_d       = brc_pkg::cmd_e'(in_cmd_i);
          sh_cnt_d    = '0;
          state_d     = (in_cmd_i == brc_pkg::CmdFinish) ? brc_pkg::StShift : brc_pkg::StMulA;
        end
      end
      brc_pkg::StMulA: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.mul_hi = 1'b1;
        state_d       = brc_pkg::StMulB;
      end
      brc_pkg::StMulB: begin
        ctrl_o.mul_en = 1'b1;
        ctrl_o.acc_en = 1'b1;
        state_d       = brc_pkg::StUpdate;
      end
      brc_pkg::StUpdate: begin
        ctrl_o.update = 1'b1;
        state_d       = brc_pkg::StShift;
      end
      brc_pkg::StShift: begin
        if (top_eq_i && (sh_cnt_q != brc_pkg::ShiftMax)) begin
          ctrl_o.shift = 1'b1;
          sh_cnt_d     = sh_cnt_q + {{(brc_pkg::ShiftCntBits-1){1'b0}}, 1'b1};
        end else begin
          state_d = (cmd_q == brc_pkg::CmdFinish) ? brc_pkg::StFlush : brc_pkg::StDone;
        end
      end
      brc_pkg::StFlush: begin
        // Final byte of the stream.
        ctrl_o.count = 1'b1;
        state_d      = brc_pkg::StDone;
      end
      brc_pkg::StDone: begin
        if (out_free_i) begin
          out_load_o   = 1'b1;
          ctrl_o.clear = (cmd_q == brc_pkg::CmdFinish);
          state_d      = brc_pkg::StIdle;
        end
      end
      default: begin
        state_d = brc_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= brc_pkg::StIdle;
      cmd_q    <= brc_pkg::CmdEncode;
      sh_cnt_q <= '0;
    end else begin
      state_q  <= state_d;
      cmd_q    <= cmd_d;
      sh_cnt_q <= sh_cnt_d;
    end
  end

  a_shift_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sh_cnt_q <= brc_pkg::ShiftMax)
    else $error("more than four byte shifts in one item");

  a_shift_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.shift |-> top_eq_i)
    else $error("byte shifted while top bytes differ");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("ready again straight after an accepted item");

  a_accept_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=>
      (state_q == brc_pkg::StMulA || state_q == brc_pkg::StShift))
    else $error("accepted item did not start its sequence");

endmodule
`default_nettype wire

/* hw/rtl/binary_range_coder_size_counter.sv */
// Top level of the binary range coder size counter.
//
//  channel | dir | payload                          | accepted when
//  in_i    | in  | cmd, coded_bit, prob_one[15:0]   | in_i.valid && in_i.ready
//  out_o   | out | byte_total[39:0], is_final       | out_o.valid && out_o.ready
//
// Encode item: the sequencer steps MulA, MulB, Update, then Shift for n byte shifts (0..4), then Done;
// one shared 16x16 multiplier forms both partial products, high half then low half.
// Finish item: Shift for n byte shifts, then Flush and Done; the shifter loops one byte per cycle.
// Reset restores the full interval and a zero count at once; no sweep.
// A result waiting in the output register holds the sequencer in its last step.
`default_nettype none
module binary_range_coder_size_counter #(
  parameter int unsigned COUNT_BITS = brc_pkg::CountBitsDefault
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  brc_in_if.sink    in_i,
  brc_out_if.source out_o
);

  brc_pkg::ctrl_t        ctrl;
  logic                  top_eq, out_free, out_load, is_final;
  logic [COUNT_BITS-1:0] count;
  logic [63:0]           count_ext;

  logic                          out_valid_q;
  logic [brc_pkg::TotalBits-1:0] total_q;
  logic                          final_q;

  assign out_free  = !out_valid_q || out_o.ready;
  assign count_ext = 64'(count);

  brc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_cmd_i   (in_i.cmd),
    .top_eq_i   (top_eq),
    .out_free_i (out_free),
    .in_ready_o (in_i.ready),
    .out_load_o (out_load),
    .is_final_o (is_final),
    .ctrl_o     (ctrl)
  );

  brc_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .coded_bit_i (in_i.coded_bit),
    .prob_one_i  (in_i.prob_one),
    .top_eq_o    (top_eq),
    .count_o     (count)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      total_q <= count_ext[brc_pkg::TotalBits-1:0];
      final_q <= is_final;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.byte_total = total_q;
  assign out_o.is_final   = final_q;

endmodule
`default_nettype wire

/* bench/binary_range_coder_size_counter_checker.sv */
// Checker for the size counter: predicts each size result and compares it.
module binary_range_coder_size_counter_checker #(
  parameter int unsigned COUNT_BITS = brc_pkg::CountBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  brc_in_if    in_mon_i,
  brc_out_if   out_mon_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   results_o,
  output int   finals_o,
  output bit   saturated_o
);

  localparam int unsigned ReportMax    = 10;
  localparam logic [63:0] CountCeiling = {64{1'b1}} >> (64 - COUNT_BITS);

  typedef struct packed {
    logic [brc_pkg::TotalBits-1:0] total;
    logic                          is_final;
  } size_result_t;

  logic [brc_pkg::RangeBits-1:0] coder_low;
  logic [brc_pkg::RangeBits-1:0] coder_high;
  logic [63:0]                   coder_bytes;
  size_result_t                  sizes_due[$];

  function automatic void restart_coder();
    coder_low   = '0;
    coder_high  = brc_pkg::FullRange;
    coder_bytes = '0;
  endfunction

  function automatic void count_byte();
    if (coder_bytes < CountCeiling) coder_bytes = coder_bytes + 64'd1;
  endfunction

  // shift out top bytes that both bounds share, four at most
  function automatic void drop_shared_bytes();
    for (int n = 0; n < int'(brc_pkg::ShiftMax); n++) begin
      if (coder_low[brc_pkg::RangeBits-1 -: 8] != coder_high[brc_pkg::RangeBits-1 -: 8]) break;
      count_byte();
      coder_low  = coder_low << 8;
      coder_high = {coder_high[brc_pkg::RangeBits-9:0], brc_pkg::FillByte};
    end
  endfunction

  function automatic size_result_t code_size_after(brc_pkg::cmd_e cmd, logic sym,
                                                   logic [brc_pkg::ProbBits-1:0] prob);
    logic [brc_pkg::RangeBits-1:0] span;
    logic [63:0]                   mid;
    logic [brc_pkg::ProbBits-1:0]  p;
    size_result_t                  res;
    p = (prob < brc_pkg::ProbMin) ? brc_pkg::ProbMin : prob;
    if (cmd == brc_pkg::CmdEncode) begin
      span = coder_high - coder_low;
      mid  = 64'(coder_low)
           + 64'(span[brc_pkg::RangeBits-1:brc_pkg::ProbBits]) * 64'(p)
           + ((64'(span[brc_pkg::ProbBits-1:0]) * 64'(p)) >> brc_pkg::ProbBits);
      if (sym) coder_high = mid[brc_pkg::RangeBits-1:0];
      else coder_low = mid[brc_pkg::RangeBits-1:0] + 32'd1;
      drop_shared_bytes();
      res.total    = coder_bytes[brc_pkg::TotalBits-1:0];
      res.is_final = 1'b0;
    end else begin
      drop_shared_bytes();
      count_byte();
      res.total    = coder_bytes[brc_pkg::TotalBits-1:0];
      res.is_final = 1'b1;
      restart_coder();
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    size_result_t seen;
    size_result_t due;
    if (!rst_ni) begin
      restart_coder();
      sizes_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
      results_o    = 0;
      finals_o     = 0;
      saturated_o  = 1'b0;
    end else begin
      if (out_mon_i.valid && out_mon_i.ready) begin
        seen.total    = out_mon_i.byte_total;
        seen.is_final = out_mon_i.is_final;
        results_o++;
        if (seen.is_final) finals_o++;
        if (seen.total == CountCeiling[brc_pkg::TotalBits-1:0]) saturated_o = 1'b1;
        if (sizes_due.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= ReportMax)
            $display("result %0d arrived with nothing outstanding: total %0d final %0b",
                     results_o, seen.total, seen.is_final);
        end else begin
          due = sizes_due.pop_front();
          if (seen.total != due.total || seen.is_final != due.is_final) begin
            fail_count_o++;
            if (fail_count_o <= ReportMax)
              $display("result %0d: wanted total %0d final %0b, got total %0d final %0b",
                       results_o, due.total, due.is_final, seen.total, seen.is_final);
          end
        end
      end
      if (in_mon_i.valid && in_mon_i.ready) begin
        due       = code_size_after(brc_pkg::cmd_e'(in_mon_i.cmd), in_mon_i.coded_bit,
                                    in_mon_i.prob_one);
        sizes_due = {sizes_due, due};
      end
      pending_o = sizes_due.size();
    end
  end

endmodule

/* bench/binary_range_coder_size_counter_test.sv */
// Top of the size counter bench: clock, reset, item stimulus, stalls and verdict.
module binary_range_coder_size_counter_test;

  localparam int unsigned CountBits   = 16;  // narrow count width, handed to block and checker
  localparam int          RandomItems = 1800;
  localparam int          DenseItems  = 200;
  localparam int          GapMax      = 6;
  localparam int          StallMax    = 5;
  localparam int          DrainCycles = 24;
  localparam int          CycleLimit  = 400000;

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   items_sent;
  int   burst_left;
  bit   gaps_on;
  int   fail_count;
  int   pending;
  int   results;
  int   finals;
  bit   saturated;

  brc_in_if  in_ch ();
  brc_out_if out_ch ();

  binary_range_coder_size_counter #(
    .COUNT_BITS(CountBits)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  binary_range_coder_size_counter_checker #(
    .COUNT_BITS(CountBits)
  ) size_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_mon_i    (in_ch),
    .out_mon_i   (out_ch),
    .fail_count_o(fail_count),
    .pending_o   (pending),
    .results_o   (results),
    .finals_o    (finals),
    .saturated_o (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("run stopped after %0d cycles with %0d results outstanding",
               cycle_count, pending);
      $display("binary_range_coder_size_counter regression: fail");
      $finish;
    end
  end

  // hold the item until accepted, then either keep the burst going or pause
  task automatic push_item(input brc_pkg::cmd_e cmd, input logic sym,
                           input logic [brc_pkg::ProbBits-1:0] prob);
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.coded_bit <= sym;
    in_ch.prob_one  <= prob;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (burst_left > 0 || !gaps_on) begin
      burst_left--;
    end else begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, GapMax)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 7);
    end
  endtask

  // receiver: switch between three stall rates, one of them never stalling
  initial begin
    int stall_left;
    int mode_left;
    int stall_odds;
    stall_left   = 0;
    mode_left    = 0;
    stall_odds   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode_left = $urandom_range(50, 300);
        case ($urandom_range(0, 2))
          0: stall_odds = 0;
          1: stall_odds = 3;
          default: stall_odds = 8;
        endcase
      end
      mode_left--;
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, StallMax - 1);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int                           stream_len;
    int                           style;
    int                           random_sent;
    logic [brc_pkg::ProbBits-1:0] prob;
    logic                         sym;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = brc_pkg::CmdEncode;
    in_ch.coded_bit = 1'b0;
    in_ch.prob_one  = '0;
    cycle_count     = 0;
    items_sent      = 0;
    burst_left      = 0;
    gaps_on         = 1'b1;
    random_sent     = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty streams, then each clamp edge and both symbols
    push_item(brc_pkg::CmdFinish, 1'b0, 16'h0000);
    push_item(brc_pkg::CmdFinish, 1'b1, 16'hffff);
    push_item(brc_pkg::CmdEncode, 1'b0, 16'h0000);
    push_item(brc_pkg::CmdEncode, 1'b1, 16'h0000);
    push_item(brc_pkg::CmdEncode, 1'b0, 16'hffff);
    push_item(brc_pkg::CmdEncode, 1'b1, 16'hffff);
    push_item(brc_pkg::CmdEncode, 1'b1, 16'h0001);
    push_item(brc_pkg::CmdEncode, 1'b0, 16'h0001);
    push_item(brc_pkg::CmdEncode, 1'b1, 16'h8000);
    push_item(brc_pkg::CmdEncode, 1'b0, 16'h8000);
    push_item(brc_pkg::CmdEncode, 1'b0, 16'hfffe);
    push_item(brc_pkg::CmdEncode, 1'b1, 16'h7fff);
    push_item(brc_pkg::CmdEncode, 1'b1, 16'h5555);
    push_item(brc_pkg::CmdEncode, 1'b0, 16'haaaa);
    push_item(brc_pkg::CmdFinish, 1'b1, 16'h1234);
    for (int i = 0; i < 3; i++) push_item(brc_pkg::CmdEncode, 1'b1, 16'h0001);
    push_item(brc_pkg::CmdFinish, 1'b0, 16'hffff);
    for (int i = 0; i < 3; i++) push_item(brc_pkg::CmdEncode, 1'b0, 16'hffff);
    push_item(brc_pkg::CmdFinish, 1'b0, 16'h0000);

    // random streams: extreme probabilities; random, likely, unlikely and constant symbols
    while (random_sent < RandomItems) begin
      stream_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 60);
      style      = $urandom_range(0, 3);
      sym        = 1'($urandom_range(0, 1));
      for (int i = 0; i < stream_len; i++) begin
        case ($urandom_range(0, 7))
          0: prob = 16'h0000;
          1: prob = 16'hffff;
          2: prob = 16'($urandom_range(1, 16));
          3: prob = 16'hffff - 16'($urandom_range(0, 16));
          default: prob = 16'($urandom);
        endcase
        case (style)
          0: sym = 1'($urandom_range(0, 1));
          1: sym = ($urandom_range(0, 65535) < 32'(prob));
          2: sym = ($urandom_range(0, 65535) >= 32'(prob));
          default: ;
        endcase
        push_item(brc_pkg::CmdEncode, sym, prob);
        random_sent++;
      end
      push_item(brc_pkg::CmdFinish, 1'($urandom_range(0, 1)), 16'($urandom));
      random_sent++;
    end

    // one gapless stream at about two bytes per item
    gaps_on = 1'b0;
    for (int i = 0; i < DenseItems; i++) begin
      if ($urandom_range(0, 1)) push_item(brc_pkg::CmdEncode, 1'b1, 16'($urandom_range(0, 1)));
      else push_item(brc_pkg::CmdEncode, 1'b0, 16'hffff);
    end
    push_item(brc_pkg::CmdFinish, 1'b0, 16'h0000);
    gaps_on = 1'b1;
    for (int i = 0; i < 4; i++) begin
      push_item(brc_pkg::CmdEncode, 1'($urandom_range(0, 1)), 16'($urandom));
    end
    push_item(brc_pkg::CmdFinish, 1'b1, 16'hffff);
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("%0d items sent: clamp and empty-stream cases, random streams, one gapless stream",
             items_sent);
    $display("%0d size results checked, %0d of them stream totals, %0d-bit count saturated: %0b",
             results, finals, CountBits, saturated);
    if (fail_count == 0) begin
      $display("binary_range_coder_size_counter regression: pass");
    end else begin
      $display("%0d mismatches counted", fail_count);
      $display("binary_range_coder_size_counter regression: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/brc_pkg.sv
hw/rtl/brc_if.sv
hw/rtl/brc_mul.sv
hw/rtl/brc_core.sv
hw/rtl/brc_ctrl.sv
hw/rtl/binary_range_coder_size_counter.sv
bench/binary_range_coder_size_counter_checker.sv
bench/binary_range_coder_size_counter_test.sv
